// ----- sv/rcr_pkg.sv -----
// Shared types and constants for the reorder commit and rollback unit.
// Holds field widths, operation and result codes, item and result structs.
// No dependencies.
package rcr_pkg;

    localparam int KIND_W = 2;
    localparam int LOG_W  = 5;
    localparam int PHYS_W = 6;
    localparam int PC_W   = 16;
    localparam int SLOT_W = 5;
    localparam int RK_W   = 3;

    // Raw kind codes on the input port.
    localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMMIT   = 2'd2;

    // Operation after classification by the front end.
    typedef enum logic [1:0] {
        OP_DISPATCH,
        OP_COMPLETE,
        OP_COMMIT,
        OP_NONE
    } op_t;

    // Result codes.
    typedef enum logic [RK_W-1:0] {
        RK_IDLE,
        RK_DISPATCHED,
        RK_REFUSED,
        RK_RETIRED,
        RK_ROLLED_BACK,
        RK_EXCEPTION,
        RK_RECOVERED
    } rk_t;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_RETIRE,
        ST_ROLLBACK
    } back_state_t;

    // Classified input item held between the front and back ends.
    typedef struct packed {
        op_t               op;
        logic [LOG_W-1:0]  dest_logical;
        logic [PHYS_W-1:0] new_physical;
        logic [PHYS_W-1:0] prior_physical;
        logic [PC_W-1:0]   inst_pc;
        logic [SLOT_W-1:0] done_slot;
        logic              faulted;
    } item_t;

    // One result item.
    typedef struct packed {
        rk_t               kind;
        logic [PHYS_W-1:0] phys_reg;
        logic [LOG_W-1:0]  log_reg;
        logic [PC_W-1:0]   fault_pc;
        logic [SLOT_W-1:0] slot;
        logic              last;
    } result_t;

    // Active list entry as stored in the entry RAM.
    typedef struct packed {
        logic [LOG_W-1:0]  dest_lreg;
        logic [PHYS_W-1:0] prior_phys;
        logic [PC_W-1:0]   pc;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- sv/rcr_ram.sv -----
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module rcr_ram #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 32
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/rcr_front.sv -----
// Front end of the reorder commit and rollback unit: a two item queue that
// accepts input transfers and classifies each kind code. Depends on rcr_pkg.
module rcr_front
    import rcr_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [KIND_W-1:0]        kind,
    input  logic [LOG_W-1:0]         dest_logical,
    input  logic [PHYS_W-1:0]        new_physical,
    input  logic [PHYS_W-1:0]        prior_physical,
    input  logic [PC_W-1:0]          inst_pc,
    input  logic [SLOT_W-1:0]        done_slot,
    input  logic                     faulted,
    output logic                     item_valid,
    output item_t                    item,
    input  logic                     item_pop
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    item_t       incoming;
    logic        do_push;
    logic        do_pop;

    // Classify the kind code and gather the payload.
    always_comb
    begin
        incoming.dest_logical   = dest_logical;
        incoming.new_physical   = new_physical;
        incoming.prior_physical = prior_physical;
        incoming.inst_pc        = inst_pc;
        incoming.done_slot      = done_slot;
        incoming.faulted        = faulted;
        unique case (kind)
            KIND_DISPATCH: incoming.op = OP_DISPATCH;
            KIND_COMPLETE: incoming.op = OP_COMPLETE;
            KIND_COMMIT:   incoming.op = OP_COMMIT;
            default:       incoming.op = OP_NONE;
        endcase
    end

    assign full       = (count_reg == 2'd2);
    assign item_valid = (count_reg != 2'd0);
    assign item       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = item_pop && item_valid;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= incoming;
        end
    end

endmodule

// ----- sv/rcr_outq.sv -----
// Result queue of the reorder commit and rollback unit: two entries that
// decouple the back end from the consumer. Depends on rcr_pkg.
module rcr_outq
    import rcr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    res_push,
    input  result_t res_in,
    output logic    res_full,
    output logic    empty,
    input  logic    pop,
    output result_t res_out
);

    result_t     slot_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        do_push;
    logic        do_pop;

    assign res_full = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign res_out  = slot_reg[rd_ptr_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule

// ----- sv/rcr_back.sv -----
// Back end of the reorder commit and rollback unit: the active list, the
// rename map and the sequencer that dispatches, completes, retires and rolls
// back. Depends on rcr_pkg and rcr_ram.
module rcr_back
    import rcr_pkg::*;
#(
    parameter int LIST_DEPTH   = 32,
    parameter int RETIRE_WIDTH = 4,
    parameter int LOGICAL_REGS = 32
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    input  item_t   item,
    output logic    item_pop,
    output logic    res_push,
    output result_t res,
    input  logic    res_full
);

    localparam int IDX_W = $clog2(LIST_DEPTH);
    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int NW    = $clog2(RETIRE_WIDTH + 1);
    localparam int MAP_W = $clog2(LOGICAL_REGS);

    back_state_t       state_reg;
    back_state_t       state_next;
    logic [IDX_W-1:0]  head_reg;
    logic [IDX_W-1:0]  head_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              recovery_reg;
    logic              recovery_next;
    logic [NW-1:0]     n_reg;
    logic [NW-1:0]     n_next;
    logic [IDX_W-1:0]  roll_idx_reg;
    logic [IDX_W-1:0]  roll_idx_next;

    logic              done_reg  [LIST_DEPTH];
    logic              fault_reg [LIST_DEPTH];
    logic [PHYS_W-1:0] map_reg   [LOGICAL_REGS];

    logic              done_we;
    logic [IDX_W-1:0]  done_idx;
    logic              done_val;
    logic              fault_val;
    logic              map_we;
    logic [MAP_W-1:0]  map_idx;
    logic [PHYS_W-1:0] map_val;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_raddr;
    entry_t            ram_wentry;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t            entry;

    logic [SUM_W-1:0]  sum;
    logic [SUM_W-1:0]  sum_m1;
    logic [IDX_W-1:0]  tail;
    logic [IDX_W-1:0]  tail_m1;
    logic [IDX_W-1:0]  head_inc;
    logic [IDX_W-1:0]  roll_prev;
    logic [6:0]        dslot_wide;
    logic [IDX_W-1:0]  dslot_idx;
    logic [SUM_W-1:0]  dslot_off;
    logic              slot_live;
    logic              disp_ok;
    logic [MAP_W-1:0]  roll_lr;
    logic              retire_go;
    logic              more_retire;
    logic              more_roll;
    logic [NW-1:0]     n_inc;

    // Entry store: logical destination, prior mapping and pc of each slot.
    rcr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (LIST_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail),
        .wdata (ram_wentry),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign entry = entry_t'(ram_rdata);

    // Ring positions: tail, youngest entry, successor of head, predecessor.
    always_comb
    begin
        sum    = SUM_W'(head_reg) + SUM_W'(count_reg);
        sum_m1 = sum - SUM_W'(1);
        tail    = (sum >= SUM_W'(LIST_DEPTH)) ?
                  IDX_W'(sum - SUM_W'(LIST_DEPTH)) : IDX_W'(sum);
        tail_m1 = (sum_m1 >= SUM_W'(LIST_DEPTH)) ?
                  IDX_W'(sum_m1 - SUM_W'(LIST_DEPTH)) : IDX_W'(sum_m1);
        head_inc  = (head_reg == IDX_W'(LIST_DEPTH - 1)) ?
                    '0 : head_reg + IDX_W'(1);
        roll_prev = (roll_idx_reg == '0) ?
                    IDX_W'(LIST_DEPTH - 1) : roll_idx_reg - IDX_W'(1);
    end

    // Completion slot check (in range and occupied) and dispatch admission check.
    always_comb
    begin
        dslot_wide = 7'(item.done_slot);
        dslot_idx  = dslot_wide[IDX_W-1:0];
        if (dslot_idx >= head_reg)
        begin
            dslot_off = SUM_W'(dslot_idx) - SUM_W'(head_reg);
        end
        else
        begin
            dslot_off = SUM_W'(dslot_idx) + SUM_W'(LIST_DEPTH) - SUM_W'(head_reg);
        end
        slot_live = (32'(item.done_slot) < LIST_DEPTH) &&
                    (dslot_off < SUM_W'(count_reg));
        disp_ok   = !recovery_reg && (count_reg != CNT_W'(LIST_DEPTH)) &&
                    (32'(item.dest_logical) < LOGICAL_REGS);
    end

    // Loop control for retire and rollback, looked ahead one result.
    always_comb
    begin
        n_inc       = n_reg + NW'(1);
        retire_go   = (n_reg < NW'(RETIRE_WIDTH)) && (count_reg != '0) &&
                      done_reg[head_reg];
        more_retire = (n_inc < NW'(RETIRE_WIDTH)) && (count_reg > CNT_W'(1)) &&
                      done_reg[head_inc];
        more_roll   = (n_inc < NW'(RETIRE_WIDTH)) && (count_reg > CNT_W'(1));
        roll_lr     = entry.dest_lreg[MAP_W-1:0];
    end

    // Sequencer: next state and datapath controls.
    always_comb
    begin
        state_next    = state_reg;
        head_next     = head_reg;
        count_next    = count_reg;
        recovery_next = recovery_reg;
        n_next        = n_reg;
        roll_idx_next = roll_idx_reg;
        item_pop      = 1'b0;
        res_push      = 1'b0;
        res           = '0;
        res.kind      = RK_IDLE;
        ram_we        = 1'b0;
        ram_wentry.dest_lreg  = item.dest_logical;
        ram_wentry.prior_phys = item.prior_physical;
        ram_wentry.pc         = item.inst_pc;
        ram_raddr     = head_reg;
        done_we       = 1'b0;
        done_idx      = tail;
        done_val      = 1'b0;
        fault_val     = 1'b0;
        map_we        = 1'b0;
        map_idx       = item.dest_logical[MAP_W-1:0];
        map_val       = item.new_physical;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid && !res_full)
                begin
                    item_pop = 1'b1;
                    res.last = 1'b1;
                    unique case (item.op)
                        OP_DISPATCH:
                        begin
                            res_push = 1'b1;
                            if (disp_ok)
                            begin
                                ram_we     = 1'b1;
                                done_we    = 1'b1;
                                map_we     = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                res.kind   = RK_DISPATCHED;
                                res.slot   = SLOT_W'(tail);
                            end
                            else
                            begin
                                res.kind = RK_REFUSED;
                            end
                        end
                        OP_COMPLETE:
                        begin
                            res_push  = 1'b1;
                            done_we   = slot_live;
                            done_idx  = dslot_idx;
                            done_val  = 1'b1;
                            fault_val = item.faulted;
                        end
                        OP_COMMIT:
                        begin
                            if (recovery_reg && (count_reg == '0))
                            begin
                                res_push      = 1'b1;
                                res.kind      = RK_RECOVERED;
                                recovery_next = 1'b0;
                            end
                            else
                            begin
                                n_next     = '0;
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            res_push = 1'b1;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                // Fetch the first entry of the loop from the entry store.
                if (recovery_reg)
                begin
                    ram_raddr     = tail_m1;
                    roll_idx_next = tail_m1;
                    state_next    = ST_ROLLBACK;
                end
                else
                begin
                    ram_raddr  = head_reg;
                    state_next = ST_RETIRE;
                end
            end

            ST_RETIRE:
            begin
                ram_raddr = head_reg;
                if (!res_full)
                begin
                    res_push = 1'b1;
                    if (!retire_go)
                    begin
                        res.last   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else if (fault_reg[head_reg])
                    begin
                        res.kind      = RK_EXCEPTION;
                        res.fault_pc  = entry.pc;
                        res.last      = 1'b1;
                        recovery_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        res.kind     = RK_RETIRED;
                        res.phys_reg = entry.prior_phys;
                        res.last     = !more_retire;
                        head_next    = head_inc;
                        count_next   = count_reg - CNT_W'(1);
                        n_next       = n_inc;
                        ram_raddr    = head_inc;
                        if (!more_retire)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end

            ST_ROLLBACK:
            begin
                ram_raddr = roll_idx_reg;
                if (!res_full)
                begin
                    res_push      = 1'b1;
                    res.kind      = RK_ROLLED_BACK;
                    res.phys_reg  = map_reg[roll_lr];
                    res.log_reg   = entry.dest_lreg;
                    res.last      = !more_roll;
                    map_we        = 1'b1;
                    map_idx       = roll_lr;
                    map_val       = entry.prior_phys;
                    count_next    = count_reg - CNT_W'(1);
                    n_next        = n_inc;
                    roll_idx_next = roll_prev;
                    ram_raddr     = roll_prev;
                    if (!more_roll)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            recovery_reg <= 1'b0;
            n_reg        <= '0;
            roll_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            recovery_reg <= recovery_next;
            n_reg        <= n_next;
            roll_idx_reg <= roll_idx_next;
        end
    end

    // Rename map, identity after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LOGICAL_REGS; i++)
            begin
                map_reg[i] <= PHYS_W'(i);
            end
        end
        else if (map_we)
        begin
            map_reg[map_idx] <= map_val;
        end
    end

    // Done and fault flags of each slot; only occupied slots are consulted.
    always_ff @(posedge clk)
    begin
        if (done_we)
        begin
            done_reg[done_idx]  <= done_val;
            fault_reg[done_idx] <= fault_val;
        end
    end

endmodule

// ----- sv/reorder_commit_rollback.sv -----
// Top level of the reorder commit and rollback unit.
// Instantiates rcr_front, rcr_back and rcr_outq; depends on rcr_pkg.
//
// In-order retirement unit with an active list ring and a rename map. Input
// transfers enter a two item queue (push/full) and are executed one at a time
// by the back end; results leave through a two entry queue (empty/pop), the
// last result of each item marked by last. Dispatch, completion, unknown
// kinds and the commit that ends recovery are each handled in ST_IDLE. A
// commit that gives k results (one to RETIRE_WIDTH) takes the item, reads
// the first entry in ST_READ, then gives the results in order, paced by
// the single registered read port of the entry store. After an exception
// every later commit cycle rolls back up to RETIRE_WIDTH youngest entries
// until a cycle finds the list empty. No clearing pass is needed after
// reset.
module reorder_commit_rollback
    import rcr_pkg::*;
#(
    parameter int LIST_DEPTH   = 32,
    parameter int RETIRE_WIDTH = 4,
    parameter int LOGICAL_REGS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [KIND_W-1:0] kind,
    input  logic [LOG_W-1:0]  dest_logical,
    input  logic [PHYS_W-1:0] new_physical,
    input  logic [PHYS_W-1:0] prior_physical,
    input  logic [PC_W-1:0]   inst_pc,
    input  logic [SLOT_W-1:0] done_slot,
    input  logic              faulted,
    output logic              empty,
    input  logic              pop,
    output logic [RK_W-1:0]   result_kind,
    output logic [PHYS_W-1:0] phys_reg,
    output logic [LOG_W-1:0]  log_reg,
    output logic [PC_W-1:0]   fault_pc,
    output logic [SLOT_W-1:0] slot,
    output logic              last
);

    logic    item_valid;
    item_t   item;
    logic    item_pop;
    logic    res_push;
    result_t res;
    logic    res_full;
    result_t res_out;

    // Front end: accept and classify.
    rcr_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .kind           (kind),
        .dest_logical   (dest_logical),
        .new_physical   (new_physical),
        .prior_physical (prior_physical),
        .inst_pc        (inst_pc),
        .done_slot      (done_slot),
        .faulted        (faulted),
        .item_valid     (item_valid),
        .item           (item),
        .item_pop       (item_pop)
    );

    // Back end: active list, rename map and sequencer.
    rcr_back #(
        .LIST_DEPTH   (LIST_DEPTH),
        .RETIRE_WIDTH (RETIRE_WIDTH),
        .LOGICAL_REGS (LOGICAL_REGS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_pop   (item_pop),
        .res_push   (res_push),
        .res        (res),
        .res_full   (res_full)
    );

    // Result queue towards the consumer.
    rcr_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .res_out  (res_out)
    );

    assign result_kind = res_out.kind;
    assign phys_reg    = res_out.phys_reg;
    assign log_reg     = res_out.log_reg;
    assign fault_pc    = res_out.fault_pc;
    assign slot        = res_out.slot;
    assign last        = res_out.last;

endmodule

// ----- test/rcr_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the reorder commit and rollback unit: watches both queue ports,
// predicts the result transfers of every accepted item and compares them in order.
// Depends on rcr_pkg.
module rcr_checker
    import rcr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic              full,
    input  logic [KIND_W-1:0] kind,
    input  logic [LOG_W-1:0]  dest_logical,
    input  logic [PHYS_W-1:0] new_physical,
    input  logic [PHYS_W-1:0] prior_physical,
    input  logic [PC_W-1:0]   inst_pc,
    input  logic [SLOT_W-1:0] done_slot,
    input  logic              faulted,
    input  logic              empty,
    input  logic              pop,
    input  logic [RK_W-1:0]   result_kind,
    input  logic [PHYS_W-1:0] phys_reg,
    input  logic [LOG_W-1:0]  log_reg,
    input  logic [PC_W-1:0]   fault_pc,
    input  logic [SLOT_W-1:0] slot,
    input  logic              last,
    output int                fail_count,
    output int                pending,
    output int                items_in
);

    localparam int DEPTH = 32;
    localparam int WIDTH = 4;
    localparam int LREGS = 32;

    typedef struct {
        logic [LOG_W-1:0]  dest_lreg;
        logic [PHYS_W-1:0] prior_phys;
        logic [PC_W-1:0]   pc;
        bit                done;
        bit                fault;
    } al_entry_t;

    // Predicted architectural state of the unit.
    al_entry_t         ring_model [DEPTH];
    logic [SLOT_W-1:0] al_head;
    int                al_count;
    logic [PHYS_W-1:0] map_table [LREGS];
    bit                recovering;

    result_t           awaited [$];
    int                errors;
    int                accepted;

    // Append one expected result transfer; the last flag is set afterwards.
    task automatic await_result(rk_t rk, logic [PHYS_W-1:0] phys, logic [LOG_W-1:0] lreg,
                                logic [PC_W-1:0] fpc, logic [SLOT_W-1:0] s);
        result_t r;
        r.kind     = rk;
        r.phys_reg = phys;
        r.log_reg  = lreg;
        r.fault_pc = fpc;
        r.slot     = s;
        r.last     = 1'b0;
        awaited.push_back(r);
    endtask

    // Work out the results of one accepted item and advance the predicted state.
    task automatic predict_rob_item(logic [KIND_W-1:0] k, logic [LOG_W-1:0] dest,
                                    logic [PHYS_W-1:0] newp, logic [PHYS_W-1:0] oldp,
                                    logic [PC_W-1:0] pc, logic [SLOT_W-1:0] dslot,
                                    logic flt);
        int                n;
        bit                halt;
        logic [SLOT_W-1:0] s;
        logic [SLOT_W-1:0] off;
        logic [LOG_W-1:0]  lr;
        n    = 0;
        halt = 1'b0;
        case (k)
            KIND_DISPATCH:
            begin
                // Refused while recovering or when the list is full.
                if (recovering || al_count >= DEPTH)
                begin
                    await_result(RK_REFUSED, '0, '0, '0, '0);
                end
                else
                begin
                    s = al_head + SLOT_W'(al_count);
                    ring_model[s].dest_lreg  = dest;
                    ring_model[s].prior_phys = oldp;
                    ring_model[s].pc         = pc;
                    ring_model[s].done       = 1'b0;
                    ring_model[s].fault      = 1'b0;
                    al_count++;
                    map_table[dest] = newp;
                    await_result(RK_DISPATCHED, '0, '0, '0, s);
                end
            end
            KIND_COMPLETE:
            begin
                // Only occupied slots are marked; anything else is just acknowledged.
                off = dslot - al_head;
                if (int'(off) < al_count)
                begin
                    ring_model[dslot].done  = 1'b1;
                    ring_model[dslot].fault = flt;
                end
                await_result(RK_IDLE, '0, '0, '0, '0);
            end
            KIND_COMMIT:
            begin
                if (recovering)
                begin
                    if (al_count == 0)
                    begin
                        recovering = 1'b0;
                        await_result(RK_RECOVERED, '0, '0, '0, '0);
                    end
                    else
                    begin
                        // Undo the youngest entries first.
                        while (n < WIDTH && al_count > 0)
                        begin
                            s  = al_head + SLOT_W'(al_count - 1);
                            lr = ring_model[s].dest_lreg;
                            await_result(RK_ROLLED_BACK, map_table[lr], lr, '0, '0);
                            map_table[lr] = ring_model[s].prior_phys;
                            al_count--;
                            n++;
                        end
                    end
                end
                else
                begin
                    // Retire done entries from the head until one is pending or faulted.
                    while (n < WIDTH && al_count > 0 && !halt)
                    begin
                        if (!ring_model[al_head].done)
                        begin
                            halt = 1'b1;
                        end
                        else if (ring_model[al_head].fault)
                        begin
                            recovering = 1'b1;
                            await_result(RK_EXCEPTION, '0, '0, ring_model[al_head].pc, '0);
                            n++;
                            halt = 1'b1;
                        end
                        else
                        begin
                            await_result(RK_RETIRED, ring_model[al_head].prior_phys,
                                         '0, '0, '0);
                            al_head = al_head + SLOT_W'(1);
                            al_count--;
                            n++;
                        end
                    end
                    if (n == 0)
                    begin
                        await_result(RK_IDLE, '0, '0, '0, '0);
                    end
                end
            end
            default:
            begin
                await_result(RK_IDLE, '0, '0, '0, '0);
            end
        endcase
        awaited[awaited.size() - 1].last = 1'b1;
    endtask

    task automatic check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want_v, got_v);
            errors++;
        end
    endtask

    // Reset the prediction with the block. Otherwise compare result transfers, then
    // predict for input transfers at the same edge, since a result can never stem
    // from an item taken at that very edge.
    always @(posedge clk)
    begin
        result_t want;
        if (!rst_n)
        begin
            al_head    = '0;
            al_count   = 0;
            recovering = 1'b0;
            for (int i = 0; i < LREGS; i++)
            begin
                map_table[i] = PHYS_W'(i);
            end
            awaited.delete();
        end
        else
        begin
            if (pop && !empty)
            begin
                if (awaited.size() == 0)
                begin
                    $error("Unexpected result transfer: result_kind %0d", result_kind);
                    errors++;
                end
                else
                begin
                    want = awaited.pop_front();
                    check_field("result_kind", want.kind, result_kind);
                    check_field("phys_reg", want.phys_reg, phys_reg);
                    check_field("log_reg", want.log_reg, log_reg);
                    check_field("fault_pc", want.fault_pc, fault_pc);
                    check_field("slot", want.slot, slot);
                    check_field("last", want.last, last);
                end
            end
            if (push && !full)
            begin
                predict_rob_item(kind, dest_logical, new_physical, prior_physical,
                                 inst_pc, done_slot, faulted);
                accepted++;
            end
        end
        fail_count <= errors;
        pending    <= awaited.size();
        items_in   <= accepted;
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench top for reorder_commit_rollback: clock, reset, stimulus and verdict.
// Depends on rcr_pkg, the block itself and rcr_checker.
module tb_top;
    import rcr_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    localparam int DEPTH        = 32;
    localparam int STALL_MAX    = 2000;
    localparam int HOLD_AT      = 60;
    localparam int HOLD_LEN     = 200;
    localparam int CALM_FROM    = 90;
    localparam int CALM_TO      = 130;
    localparam int RANDOM_ITEMS = 128;
    localparam int FILL_AT      = 70;

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              push           = 1'b0;
    logic              full;
    logic [KIND_W-1:0] kind           = '0;
    logic [LOG_W-1:0]  dest_logical   = '0;
    logic [PHYS_W-1:0] new_physical   = '0;
    logic [PHYS_W-1:0] prior_physical = '0;
    logic [PC_W-1:0]   inst_pc        = '0;
    logic [SLOT_W-1:0] done_slot      = '0;
    logic              faulted        = 1'b0;
    logic              empty;
    logic              pop            = 1'b0;
    logic [RK_W-1:0]   result_kind;
    logic [PHYS_W-1:0] phys_reg;
    logic [LOG_W-1:0]  log_reg;
    logic [PC_W-1:0]   fault_pc;
    logic [SLOT_W-1:0] slot;
    logic              last;

    int fail_count;
    int pending;
    int items_in;
    int sent  = 0;
    int quiet = 0;

    // Occupancy of the active list as the sender sees it, used to steer the stimulus.
    logic [SLOT_W-1:0] plan_head       = '0;
    int                plan_count      = 0;
    bit                plan_recovering = 1'b0;
    bit                plan_done [DEPTH];
    bit                plan_fault [DEPTH];
    bit                fill_mode       = 1'b0;

    reorder_commit_rollback dut (.*);

    rcr_checker commit_check (.*);

    always #6 clk = ~clk;

    // Track list occupancy after each input transfer.
    task automatic note_sent(logic [KIND_W-1:0] k, logic [SLOT_W-1:0] dslot, logic flt);
        logic [SLOT_W-1:0] s;
        int                n;
        bit                halt;
        n    = 0;
        halt = 1'b0;
        case (k)
            KIND_DISPATCH:
            begin
                if (!plan_recovering && plan_count < DEPTH)
                begin
                    s = plan_head + SLOT_W'(plan_count);
                    plan_done[s]  = 1'b0;
                    plan_fault[s] = 1'b0;
                    plan_count++;
                end
            end
            KIND_COMPLETE:
            begin
                s = dslot - plan_head;
                if (int'(s) < plan_count)
                begin
                    plan_done[dslot]  = 1'b1;
                    plan_fault[dslot] = flt;
                end
            end
            KIND_COMMIT:
            begin
                if (plan_recovering)
                begin
                    if (plan_count == 0)
                        plan_recovering = 1'b0;
                    else
                        plan_count -= (plan_count < 4) ? plan_count : 4;
                end
                else
                begin
                    while (n < 4 && plan_count > 0 && !halt)
                    begin
                        if (!plan_done[plan_head])
                            halt = 1'b1;
                        else if (plan_fault[plan_head])
                        begin
                            plan_recovering = 1'b1;
                            halt = 1'b1;
                        end
                        else
                        begin
                            plan_head = plan_head + SLOT_W'(1);
                            plan_count--;
                            n++;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // Offer one item, with an occasional gap first, and wait for its transfer.
    task automatic send_item(logic [KIND_W-1:0] k, logic [LOG_W-1:0] dest,
                             logic [PHYS_W-1:0] newp, logic [PHYS_W-1:0] oldp,
                             logic [PC_W-1:0] pc, logic [SLOT_W-1:0] dslot, logic flt);
        int gap;
        gap = 0;
        if ((sent < CALM_FROM || sent >= CALM_TO) && $urandom_range(99) < 29)
            gap = ($urandom_range(9) == 0) ? $urandom_range(6, 2) : 1;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push           <= 1'b1;
        kind           <= k;
        dest_logical   <= dest;
        new_physical   <= newp;
        prior_physical <= oldp;
        inst_pc        <= pc;
        done_slot      <= dslot;
        faulted        <= flt;
        do
            @(posedge clk);
        while (full);
        sent++;
        note_sent(k, dslot, flt);
    endtask

    // Mostly well-formed traffic: completions aimed at occupied slots, recoveries
    // driven to their end, one fill of the whole list; the rest is noise.
    task automatic send_random_item();
        int                r;
        logic [KIND_W-1:0] k;
        logic [SLOT_W-1:0] s;
        logic              flt;
        r   = $urandom_range(99);
        s   = SLOT_W'($urandom_range(31));
        flt = 1'($urandom_range(1));
        if (plan_recovering)
        begin
            if (r < 65)
                k = KIND_COMMIT;
            else if (r < 80)
                k = KIND_DISPATCH;
            else if (r < 92)
                k = KIND_COMPLETE;
            else
                k = KIND_UNUSED;
        end
        else if (fill_mode)
        begin
            // The dispatch that finds the list full closes the fill.
            k = KIND_DISPATCH;
            if (plan_count >= DEPTH)
                fill_mode = 1'b0;
        end
        else if (r < 35)
            k = KIND_DISPATCH;
        else if (r < 65)
        begin
            k = KIND_COMPLETE;
            if (plan_count > 0)
            begin
                s   = plan_head + SLOT_W'($urandom_range(plan_count - 1));
                flt = ($urandom_range(99) < 6);
            end
        end
        else if (r < 88)
            k = KIND_COMMIT;
        else if (r < 94)
            k = KIND_COMPLETE;
        else
            k = KIND_UNUSED;
        send_item(k, LOG_W'($urandom_range(31)), PHYS_W'($urandom_range(63)),
                  PHYS_W'($urandom_range(63)), PC_W'($urandom_range(65535)), s, flt);
    endtask

    // Receiver: random pops, one long hold-off to fill the block, and a calm stretch.
    initial
    begin : receiver
        int hold_left;
        bit held;
        hold_left = 0;
        held      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && items_in >= HOLD_AT)
            begin
                held      = 1'b1;
                hold_left = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                pop <= 1'b0;
                hold_left--;
            end
            else if (items_in >= CALM_FROM && items_in < CALM_TO)
                pop <= 1'b1;
            else
                pop <= ($urandom_range(99) >= 29);
        end
    end

    // Watchdog: count cycles without any transfer.
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
            quiet <= 0;
        else if (quiet >= STALL_MAX)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    // Stimulus and verdict.
    initial
    begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle commit on an empty list, an unknown kind, completion of an empty slot.
        send_item(KIND_COMMIT, '0, '0, '0, '0, '0, 1'b0);
        send_item(KIND_UNUSED, 5'd31, 6'd63, 6'd63, 16'hFFFF, 5'd31, 1'b1);
        send_item(KIND_COMPLETE, '0, '0, '0, '0, 5'd31, 1'b1);

        // Seven dispatches with extreme field values; register 31 is renamed twice.
        send_item(KIND_DISPATCH, 5'd0, 6'd63, 6'd0, 16'h0000, '0, 1'b0);
        send_item(KIND_DISPATCH, 5'd31, 6'd0, 6'd63, 16'hFFFF, '0, 1'b0);
        send_item(KIND_DISPATCH, 5'd5, 6'd40, 6'd5, 16'h1234, '0, 1'b0);
        send_item(KIND_DISPATCH, 5'd31, 6'd33, 6'd0, 16'h8000, '0, 1'b0);
        send_item(KIND_DISPATCH, 5'd10, 6'd21, 6'd10, 16'h00A5, '0, 1'b0);
        send_item(KIND_DISPATCH, 5'd11, 6'd42, 6'd11, 16'h5A00, '0, 1'b0);
        send_item(KIND_DISPATCH, 5'd20, 6'd52, 6'd20, 16'h0F0F, '0, 1'b0);

        // Head not yet done: nothing retires.
        send_item(KIND_COMMIT, '0, '0, '0, '0, '0, 1'b0);

        // Complete out of order, with a fault on the fourth entry.
        send_item(KIND_COMPLETE, '0, '0, '0, '0, 5'd1, 1'b0);
        send_item(KIND_COMPLETE, '0, '0, '0, '0, 5'd0, 1'b0);
        send_item(KIND_COMPLETE, '0, '0, '0, '0, 5'd2, 1'b0);
        send_item(KIND_COMPLETE, '0, '0, '0, '0, 5'd3, 1'b1);
        send_item(KIND_COMPLETE, '0, '0, '0, '0, 5'd4, 1'b0);

        // Three retirements then the exception; a dispatch refused during recovery;
        // a full rollback of four; end of recovery; then an idle commit.
        send_item(KIND_COMMIT, '0, '0, '0, '0, '0, 1'b0);
        send_item(KIND_DISPATCH, 5'd7, 6'd7, 6'd7, 16'h7777, '0, 1'b0);
        send_item(KIND_COMMIT, '0, '0, '0, '0, '0, 1'b0);
        send_item(KIND_COMMIT, '0, '0, '0, '0, '0, 1'b0);
        send_item(KIND_COMMIT, '0, '0, '0, '0, '0, 1'b0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == FILL_AT)
                fill_mode = 1'b1;
            send_random_item();
        end
        push <= 1'b0;

        // Drain, then allow for a commit still in flight.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/rcr_pkg.sv
sv/rcr_ram.sv
sv/rcr_front.sv
sv/rcr_outq.sv
sv/rcr_back.sv
sv/reorder_commit_rollback.sv
test/rcr_checker.sv
test/tb_top.sv
